// ===== src/gbct_pkg.sv =====
// Shared types and constants for the gyro bias calibration / tilt classifier.
// No dependencies; every other file in src imports this package.
`default_nettype none

package gbct_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 23;
    localparam int COUNT_W  = 7;
    localparam int THR_W    = 15;
    localparam int DIR_W    = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd1000;

    // Register index decoded from the word address bit
    localparam logic REG_MOVEMENT_THRESHOLD = 1'b0;

    typedef enum logic
    {
        OP_CAL  = 1'b0,
        OP_MEAS = 1'b1
    } opcode_t;

    typedef enum logic [DIR_W-1:0]
    {
        DIR_NONE  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } dir_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [THR_W-1:0]    thr_t;

    typedef struct packed
    {
        sample_t corrected_x;
        sample_t corrected_y;
        sample_t corrected_z;
        dir_t    direction;
        logic    calibration_done;
    } result_t;

endpackage

`default_nettype wire

// ===== src/gbct_div.sv =====
// Signed divide of a calibration sum by a fixed sample count, truncated toward zero.
// Uses a reciprocal multiply that is exact for any 23-bit magnitude; depends on gbct_pkg.
`default_nettype none

module gbct_div #(
    parameter int DIVISOR = 100
) (
    input  gbct_pkg::sum_t    sum,
    output gbct_pkg::sample_t quotient
);
    import gbct_pkg::*;

    localparam int SHIFT  = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic              negative;
    logic [SUM_W-1:0]  magnitude;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] shifted;
    logic [SAMPLE_W-1:0] mag_quot;

    always_comb
    begin
        negative  = sum[SUM_W-1];
        magnitude = negative ? (~sum + 1'b1) : sum;
        product   = PROD_W'(magnitude) * PROD_W'(RECIP);
        shifted   = product >> SHIFT;
        mag_quot  = shifted[SAMPLE_W-1:0];
        // restore the sign; result wraps to 16 bits
        quotient  = negative ? sample_t'(~mag_quot + 1'b1) : sample_t'(mag_quot);
    end

endmodule

`default_nettype wire

// ===== src/gbct_cfg.sv =====
// APB register file holding the movement threshold.
// Depends on gbct_pkg.
`default_nettype none

module gbct_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbct_pkg::APB_AW-1:0]  paddr,
    input  logic [gbct_pkg::APB_DW-1:0]  pwdata,
    output logic [gbct_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output gbct_pkg::thr_t               threshold
);
    import gbct_pkg::*;

    thr_t threshold_reg;
    thr_t threshold_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (wr_en && (paddr[2] == REG_MOVEMENT_THRESHOLD))
        begin
            threshold_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MOVEMENT_THRESHOLD)
        begin
            prdata = APB_DW'(threshold_reg);
        end
    end

    assign threshold = threshold_reg;

endmodule

`default_nettype wire

// ===== src/gbct_core.sv =====
// Calibration accumulators, bias offsets, offset correction and tilt decision.
// Depends on gbct_pkg and gbct_div.
`default_nettype none

module gbct_core #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  gbct_pkg::opcode_t   opcode,
    input  gbct_pkg::sample_t   raw_x,
    input  gbct_pkg::sample_t   raw_y,
    input  gbct_pkg::sample_t   raw_z,
    input  gbct_pkg::thr_t      threshold,
    output gbct_pkg::result_t   result
);
    import gbct_pkg::*;

    sum_t                sum_x_reg, sum_y_reg, sum_z_reg;
    sum_t                sum_x_next, sum_y_next, sum_z_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    sample_t             offset_x_reg, offset_y_reg, offset_z_reg;
    sample_t             offset_x_next, offset_y_next, offset_z_next;

    sum_t                sum_x_new, sum_y_new, sum_z_new;
    logic [COUNT_W-1:0]  count_new;
    sample_t             avg_x, avg_y, avg_z;
    sample_t             cx, cy, cz;
    logic signed [SAMPLE_W:0] x_ext, y_ext, thr_pos, thr_neg;
    logic                is_cal;
    logic                done;
    dir_t                dir;

    assign is_cal    = (opcode == OP_CAL);
    assign sum_x_new = sum_x_reg + SUM_W'(raw_x);
    assign sum_y_new = sum_y_reg + SUM_W'(raw_y);
    assign sum_z_new = sum_z_reg + SUM_W'(raw_z);
    assign count_new = count_reg + 1'b1;
    assign done      = is_cal && (count_new >= COUNT_W'(CAL_SAMPLES));

    gbct_div #(.DIVISOR(CAL_SAMPLES)) u_div_x (.sum(sum_x_new), .quotient(avg_x));
    gbct_div #(.DIVISOR(CAL_SAMPLES)) u_div_y (.sum(sum_y_new), .quotient(avg_y));
    gbct_div #(.DIVISOR(CAL_SAMPLES)) u_div_z (.sum(sum_z_new), .quotient(avg_z));

    // Correct and classify; X wins over Y
    always_comb
    begin
        cx      = raw_x - offset_x_reg;
        cy      = raw_y - offset_y_reg;
        cz      = raw_z - offset_z_reg;
        x_ext   = (SAMPLE_W+1)'(cx);
        y_ext   = (SAMPLE_W+1)'(cy);
        thr_pos = $signed({2'b00, threshold});
        thr_neg = -thr_pos;
        if (x_ext > thr_pos)
            dir = DIR_RIGHT;
        else if (x_ext < thr_neg)
            dir = DIR_LEFT;
        else if (y_ext > thr_pos)
            dir = DIR_UP;
        else if (y_ext < thr_neg)
            dir = DIR_DOWN;
        else
            dir = DIR_NONE;
    end

    always_comb
    begin
        result = '0;
        if (is_cal)
        begin
            result.direction        = DIR_NONE;
            result.calibration_done = done;
        end
        else
        begin
            result.corrected_x = cx;
            result.corrected_y = cy;
            result.corrected_z = cz;
            result.direction   = dir;
        end
    end

    always_comb
    begin
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_z_next    = sum_z_reg;
        count_next    = count_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        offset_z_next = offset_z_reg;
        if (step && is_cal)
        begin
            if (done)
            begin
                offset_x_next = avg_x;
                offset_y_next = avg_y;
                offset_z_next = avg_z;
                sum_x_next    = '0;
                sum_y_next    = '0;
                sum_z_next    = '0;
                count_next    = '0;
            end
            else
            begin
                sum_x_next = sum_x_new;
                sum_y_next = sum_y_new;
                sum_z_next = sum_z_new;
                count_next = count_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            count_reg    <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else
        begin
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_z_reg    <= sum_z_next;
            count_reg    <= count_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            offset_z_reg <= offset_z_next;
        end
    end

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(CAL_SAMPLES))
        else $error("calibration count reached the sample limit");

    a_done_clears_sums: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> (sum_x_reg == '0) && (sum_y_reg == '0) && (sum_z_reg == '0)
                         && (count_reg == '0))
        else $error("sums not cleared after calibration");

    a_meas_keeps_sums: assert property (@(posedge clk) disable iff (!rst_n)
        step && !is_cal |=> $stable(count_reg) && $stable(sum_x_reg))
        else $error("measurement disturbed calibration state");

endmodule

`default_nettype wire

// ===== src/gyro_bias_calibrate_tilt_classify.sv =====
// Gyro bias calibration and tilt classifier. Each transfer on the input channel
// carries an opcode and a signed 16-bit X/Y/Z rate sample and yields exactly one
// result transfer. Calibration samples (opcode 0) are summed per axis; the sample
// that brings the count to CAL_SAMPLES loads each bias offset with its sum divided
// by CAL_SAMPLES (truncated toward zero), clears the sums and count, and flags
// calibration_done. Those results carry zero corrected axes and no direction.
// Measurement samples (opcode 1) return raw minus offset, wrapped to 16 bits, and
// a tilt direction: X beyond +/- movement_threshold first (right/left), then Y
// (up/down). Offsets start at zero, so uncalibrated samples pass straight through.
// Timing: one transfer per cycle sustained while the result is not stalled; a
// result passes through the input register, then the result register, before it
// is presented. Output stalls hold both stages, and the input stalls only while
// both stages are full and the result is stalled.
// The offset divide is a reciprocal multiply, so calibration completion never
// stalls the pipeline. movement_threshold lives at APB byte address 0 (reset 1000)
// and may only be written while no transfer is in flight.
`default_nettype none

module gyro_bias_calibrate_tilt_classify #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    input  logic signed [15:0]  raw_z,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  corrected_x,
    output logic signed [15:0]  corrected_y,
    output logic signed [15:0]  corrected_z,
    output logic [2:0]          direction,
    output logic                calibration_done,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gbct_pkg::*;

    // Input register stage
    logic    s1_valid_reg, s1_valid_next;
    opcode_t s1_opcode_reg;
    sample_t s1_x_reg, s1_y_reg, s1_z_reg;

    // Result register stage
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;

    result_t core_result;
    thr_t    threshold;
    logic    s1_advance;
    logic    in_take;

    // Move the stage-1 item into the result register whenever that register is
    // empty or is being drained this cycle.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= opcode_t'(opcode);
            s1_x_reg      <= raw_x;
            s1_y_reg      <= raw_y;
            s1_z_reg      <= raw_z;
        end
        if (s1_advance)
        begin
            out_result_reg <= core_result;
        end
    end

    gbct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // State commits on the same edge the result is captured
    gbct_core #(.CAL_SAMPLES(CAL_SAMPLES)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_advance),
        .opcode    (s1_opcode_reg),
        .raw_x     (s1_x_reg),
        .raw_y     (s1_y_reg),
        .raw_z     (s1_z_reg),
        .threshold (threshold),
        .result    (core_result)
    );

    assign out_valid        = out_valid_reg;
    assign corrected_x      = out_result_reg.corrected_x;
    assign corrected_y      = out_result_reg.corrected_y;
    assign corrected_z      = out_result_reg.corrected_z;
    assign direction        = out_result_reg.direction;
    assign calibration_done = out_result_reg.calibration_done;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_done_has_no_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibration_done |->
            (direction == DIR_NONE) && (corrected_x == '0) && (corrected_y == '0)
            && (corrected_z == '0))
        else $error("calibration result carries measurement data");

    a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced item lost before result register");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for gyro_bias_calibrate_tilt_classify: sends samples,
// writes the threshold over APB and checks every result against its own predictor.
// Depends on gbct_pkg (src/gbct_pkg.sv) and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbct_pkg::*;

    localparam int CAL_SAMPLES    = 100;
    localparam int ITEM_TARGET    = 1200;
    localparam int WATCHDOG_LIMIT = 4000;
    // The threshold register sits at word 0; the word index is paddr[2]
    localparam logic [APB_AW-1:0] THRESHOLD_ADDR = {REG_MOVEMENT_THRESHOLD, 2'b00};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                opcode;
    logic signed [15:0]  raw_x;
    logic signed [15:0]  raw_y;
    logic signed [15:0]  raw_z;
    logic                out_valid;
    logic                out_stall;
    logic signed [15:0]  corrected_x;
    logic signed [15:0]  corrected_y;
    logic signed [15:0]  corrected_z;
    logic [2:0]          direction;
    logic                calibration_done;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor copy of the calibration state and the threshold register
    sum_t                acc_x = '0;
    sum_t                acc_y = '0;
    sum_t                acc_z = '0;
    logic [COUNT_W-1:0]  acc_count = '0;
    sample_t             bias_x = '0;
    sample_t             bias_y = '0;
    sample_t             bias_z = '0;
    thr_t                tilt_threshold = THRESHOLD_RESET;

    result_t             expected_results[$];
    int                  fail_count = 0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;
    bit                  no_idle = 1'b0;

    gyro_bias_calibrate_tilt_classify #(.CAL_SAMPLES(CAL_SAMPLES)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back-to-back, often a short gap, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the calibration state by one sample and return the result it yields
    function automatic result_t predict_result(opcode_t op, sample_t x, sample_t y,
                                               sample_t z);
        result_t r;
        sample_t dx, dy, dz;
        int      cx, cy, thr;
        r = '0;
        if (op == OP_CAL)
        begin
            acc_x     = acc_x + sum_t'(x);
            acc_y     = acc_y + sum_t'(y);
            acc_z     = acc_z + sum_t'(z);
            acc_count = acc_count + 1'b1;
            if (acc_count >= CAL_SAMPLES)
            begin
                // int division truncates toward zero, as the offset must
                bias_x    = sample_t'(int'(acc_x) / CAL_SAMPLES);
                bias_y    = sample_t'(int'(acc_y) / CAL_SAMPLES);
                bias_z    = sample_t'(int'(acc_z) / CAL_SAMPLES);
                acc_x     = '0;
                acc_y     = '0;
                acc_z     = '0;
                acc_count = '0;
                r.calibration_done = 1'b1;
            end
        end
        else
        begin
            dx  = x - bias_x;
            dy  = y - bias_y;
            dz  = z - bias_z;
            cx  = dx;
            cy  = dy;
            thr = int'(tilt_threshold);
            r.corrected_x = dx;
            r.corrected_y = dy;
            r.corrected_z = dz;
            // X wins over Y; both need to be strictly beyond the threshold
            if (cx > thr)
                r.direction = DIR_RIGHT;
            else if (cx < -thr)
                r.direction = DIR_LEFT;
            else if (cy > thr)
                r.direction = DIR_UP;
            else if (cy < -thr)
                r.direction = DIR_DOWN;
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Present one sample and hold it until the transfer; valid stays high after
    // the transfer so a following zero-gap sample goes out without a bubble.
    task automatic send_sample(opcode_t op, sample_t x, sample_t y, sample_t z);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        raw_x    <= x;
        raw_y    <= y;
        raw_z    <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_result(op, x, y, z));
        items_sent++;
    endtask

    // Measurement whose corrected axes come out as given under the current offsets
    task automatic send_corrected(sample_t cx, sample_t cy, sample_t cz);
        send_sample(OP_MEAS, cx + bias_x, cy + bias_y, cz + bias_z);
    endtask

    // Corrected axis: uniform, just around +/- threshold, or inside the dead band
    function automatic sample_t pick_axis();
        int r, mag;
        r   = $urandom_range(0, 9);
        mag = int'(tilt_threshold) + int'($urandom_range(0, 2)) - 1;
        if (r < 3)
            return sample_t'($urandom());
        if (r < 5)
            return sample_t'(mag);
        if (r < 7)
            return sample_t'(-mag);
        return sample_t'(int'($urandom_range(0, 2 * tilt_threshold)) - int'(tilt_threshold));
    endfunction

    task automatic send_random_measurement();
        send_corrected(pick_axis(), pick_axis(), sample_t'($urandom()));
    endtask

    function automatic sample_t jitter(sample_t center, int spread);
        return sample_t'(int'(center) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Hold off the sender until every outstanding result has come back.
    // Each sample yields a result, so an empty queue means the block is idle.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_transfer(logic is_write, logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the threshold while idle, then read it back
    task automatic write_threshold(thr_t value);
        logic [APB_DW-1:0] rd;
        drain_pipeline();
        apb_transfer(1'b1, APB_DW'(value), rd);
        tilt_threshold = value;
        apb_transfer(1'b0, '0, rd);
        compare_field("movement_threshold", APB_DW'(value), rd);
    endtask

    // Feed calibration samples around a random bias, mixing in measurements
    task automatic run_calibration(int count);
        sample_t cx, cy, cz;
        int      spread, mix_pct;
        spread  = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 2000);
        mix_pct = $urandom_range(0, 20);
        cx      = sample_t'($urandom());
        cy      = sample_t'($urandom());
        cz      = sample_t'($urandom());
        while (count > 0)
        begin
            if ($urandom_range(0, 99) < mix_pct)
                send_random_measurement();
            else
            begin
                send_sample(OP_CAL, jitter(cx, spread), jitter(cy, spread),
                            jitter(cz, spread));
                count--;
            end
        end
    endtask

    // Reset value of the register, uncalibrated pass-through, boundaries, priority
    task automatic test_reset_state();
        logic [APB_DW-1:0] rd;
        apb_transfer(1'b0, '0, rd);
        compare_field("movement_threshold", APB_DW'(THRESHOLD_RESET), rd);
        send_sample(OP_MEAS, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_sample(OP_MEAS, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_sample(OP_MEAS, 16'sd0, 16'sd0, 16'sd0);
        send_sample(OP_MEAS, -16'sd1, -16'sd1, -16'sd1);
        send_corrected(1000, 0, 0);
        send_corrected(1001, 0, 0);
        send_corrected(-1000, 0, 0);
        send_corrected(-1001, 0, 0);
        send_corrected(0, 1000, 0);
        send_corrected(0, 1001, 0);
        send_corrected(0, -1001, 0);
        send_corrected(1001, -1001, 0);
        send_corrected(-1001, 1001, 0);
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_corrected(0, 0, 0);
        send_corrected(1, 0, 0);
        send_corrected(-1, 0, 0);
        send_corrected(0, 1, 0);
        send_corrected(0, -1, 0);
        // At full scale only the most negative value gets past the threshold
        write_threshold({THR_W{1'b1}});
        send_corrected(16'sh7FFF, 16'sh7FFF, 0);
        send_corrected(16'sh8000, 0, 0);
        send_corrected(0, 16'sh8000, 0);
    endtask

    // Full-scale sums, truncation toward zero and a measurement mid-calibration
    task automatic test_calibration_extremes();
        write_threshold(THRESHOLD_RESET);
        for (int i = 0; i < CAL_SAMPLES; i++)
        begin
            // A measurement in the middle must leave the sums and count alone
            if (i == CAL_SAMPLES / 2)
                send_sample(OP_MEAS, 16'sd0, 16'sd0, 16'sd0);
            // Z sums to -150 so its offset truncates to -1, not -2
            send_sample(OP_CAL, 16'sh7FFF, 16'sh8000, (i == 0) ? -16'sd150 : 16'sd0);
        end
        send_sample(OP_MEAS, 16'sh7FFF, 16'sh8000, 16'sd0);
        send_sample(OP_MEAS, 16'sh8000, 16'sh7FFF, -16'sd1);
    endtask

    // Phases of well-formed calibration runs and measurement bursts, each under a
    // fresh threshold; a few runs break off early and leave a partial sum behind.
    task automatic test_random_traffic();
        int   n;
        thr_t thr;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       thr = '0;
                1:       thr = {THR_W{1'b1}};
                2:       thr = THRESHOLD_RESET;
                3:       thr = thr_t'($urandom());
                default: thr = thr_t'($urandom_range(0, 3000));
            endcase
            write_threshold(thr);
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 6)
            begin
                n = CAL_SAMPLES - int'(acc_count);
                if ($urandom_range(0, 6) == 0)
                    n = $urandom_range(1, n);
                run_calibration(n);
            end
            else
            begin
                repeat ($urandom_range(30, 120))
                    send_random_measurement();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= OP_CAL;
        raw_x    <= '0;
        raw_y    <= '0;
        raw_z    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_threshold_extremes();
        test_calibration_extremes();
        test_random_traffic();

        drain_pipeline();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Result side back-pressure: random stalls, skipped while no_idle is set
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = no_idle ? 0 : pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Match each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no sample awaiting it");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("corrected_x", want.corrected_x, corrected_x);
                compare_field("corrected_y", want.corrected_y, corrected_y);
                compare_field("corrected_z", want.corrected_z, corrected_z);
                compare_field("direction", want.direction, direction);
                compare_field("calibration_done", want.calibration_done, calibration_done);
            end
        end
    end

    // Drop the run if nothing moves on any port for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

endmodule
